// ----- design/point_in_polygon_test_macros.svh -----
// Assertion helpers used by point_in_polygon_test.sv.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PIP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/pip_pkg.sv -----
package pip_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_POINT_X = 2'd0;
   localparam csr_index_type CSR_POINT_Y = 2'd1;

   // Outcome of one edge test
   typedef struct packed {
      logic on_edge;
      logic crossing;
   } edge_res_type;

endpackage

// ----- design/point_in_polygon_test.sv -----
// Point-in-polygon test by upward ray casting over a stream of vertices. Set the point
// through the csr port (index 0 = x, index 1 = y, other indexes are ignored) while the
// block is idle. Send vertices one per item; tuser marks the last vertex of a component
// and tlast the last vertex of the whole set (tlast also closes the open component).
// Each closed component yields one result item: component_inside is 1 when the point is
// inside or on that component's boundary, object_inside is the running parity of the
// containing components of the current set, and tlast (object_done) ends the set. Items
// that do not close a component yield nothing. The block takes one vertex every cycle
// unless an untaken result holds the result register; a closing vertex passes the input
// register, then the result register, before its result is offered. An edge unit for the
// current edge and one for the closing edge each hold a pair of exact (COORD_BITS+1)-square multiplies.
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test #(
   parameter  int COORD_BITS    = pip_pkg::COORD_BITS_DEFAULT,
   localparam int REQ_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  pip_pkg::csr_index_type        csr_index,
   input  logic [COORD_BITS-1:0]         csr_data,
   // vertex items
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_DATA_BITS-1:0]      req_tdata,  // vertex_x, vertex_y, zero pad
   input  logic                          req_tuser,  // closes_component
   input  logic                          req_tlast,  // closes_object
   // result items
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // component_inside, object_inside, pad
   output logic                          rsp_tlast   // object_done
);

   // Configured point
   logic signed [COORD_BITS-1:0] point_x_ff, point_y_ff;

   // Input register
   logic                         in_valid_ff, in_valid_in;
   logic signed [COORD_BITS-1:0] in_x_ff, in_y_ff;
   logic                         in_comp_ff, in_obj_ff;

   // Component walk state
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic                         open_ff, open_in;
   logic                         parity_ff, parity_in;
   logic                         onedge_ff, onedge_in;
   logic                         objp_ff, objp_in;

   // Result register
   logic                         out_valid_ff, out_valid_in;
   logic                         out_comp_ff, out_obj_ff, out_done_ff;

   logic                         advance;
   logic                         closes;
   logic signed [COORD_BITS-1:0] first_x_eff, first_y_eff;
   pip_pkg::edge_res_type        walk_edge, close_edge;
   logic                         parity_acc, onedge_acc;
   logic                         comp_hit, objp_new;

   assign csr_ready = 1'b1;

   // Move the held vertex on when the result register can take whatever it yields
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign closes     = in_comp_ff || in_obj_ff;

   // A vertex that opens a component is also its first vertex
   assign first_x_eff = open_ff ? first_x_ff : in_x_ff;
   assign first_y_eff = open_ff ? first_y_ff : in_y_ff;

   // Edge from the previous vertex to this one
   pip_edge #(.COORD_BITS(COORD_BITS)) u_walk_edge (
      .point_x (point_x_ff),
      .point_y (point_y_ff),
      .xa      (prev_x_ff),
      .ya      (prev_y_ff),
      .xb      (in_x_ff),
      .yb      (in_y_ff),
      .result  (walk_edge)
   );

   // Closing edge from this vertex back to the first one
   pip_edge #(.COORD_BITS(COORD_BITS)) u_close_edge (
      .point_x (point_x_ff),
      .point_y (point_y_ff),
      .xa      (in_x_ff),
      .ya      (in_y_ff),
      .xb      (first_x_eff),
      .yb      (first_y_eff),
      .result  (close_edge)
   );

   // Accumulate the walk edge only inside an open component
   assign parity_acc = open_ff && (parity_ff ^ walk_edge.crossing);
   assign onedge_acc = open_ff && (onedge_ff || walk_edge.on_edge);
   assign comp_hit   = onedge_acc || close_edge.on_edge || (parity_acc ^ close_edge.crossing);
   assign objp_new   = objp_ff ^ comp_hit;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      open_in   = open_ff;
      parity_in = parity_ff;
      onedge_in = onedge_ff;
      objp_in   = objp_ff;
      if (advance) begin
         if (closes) begin
            // Drop the component state; clear the set parity at the end of a set
            open_in   = 1'b0;
            parity_in = 1'b0;
            onedge_in = 1'b0;
            objp_in   = in_obj_ff ? 1'b0 : objp_new;
         end else begin
            open_in   = 1'b1;
            parity_in = parity_acc;
            onedge_in = onedge_acc;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && closes) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         open_ff      <= 1'b0;
         parity_ff    <= 1'b0;
         onedge_ff    <= 1'b0;
         objp_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         open_ff      <= open_in;
         parity_ff    <= parity_in;
         onedge_ff    <= onedge_in;
         objp_ff      <= objp_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pip_pkg::CSR_POINT_X: point_x_ff <= csr_data;
               pip_pkg::CSR_POINT_Y: point_y_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_x_ff    <= req_tdata[COORD_BITS-1:0];
         in_y_ff    <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         in_comp_ff <= req_tuser;
         in_obj_ff  <= req_tlast;
      end
      if (advance) begin
         prev_x_ff <= in_x_ff;
         prev_y_ff <= in_y_ff;
         if (!open_ff) begin
            first_x_ff <= in_x_ff;
            first_y_ff <= in_y_ff;
         end
      end
      if (advance && closes) begin
         out_comp_ff <= comp_hit;
         out_obj_ff  <= objp_new;
         out_done_ff <= in_obj_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_obj_ff, out_comp_ff};
   assign rsp_tlast  = out_done_ff;

   `PIP_ASSERT_NOW(a_closed_state_clear, clock, reset, !open_ff, !parity_ff && !onedge_ff, "component state set while no component is open")
   `PIP_ASSERT_NEXT(a_close_drops_open, clock, reset, advance && closes, !open_ff, "component still open after its closing vertex")
   `PIP_ASSERT_NEXT(a_set_end_clears, clock, reset, advance && in_obj_ff, !objp_ff, "set parity kept past the end of a set")
   `PIP_ASSERT_NOW(a_result_source, clock, reset, $rose(out_valid_ff), $past(advance && closes), "result raised without a closing vertex")

endmodule

// ----- design/pip_edge.sv -----
module pip_edge #(
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT
) (
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic signed [COORD_BITS-1:0] xa,
   input  logic signed [COORD_BITS-1:0] ya,
   input  logic signed [COORD_BITS-1:0] xb,
   input  logic signed [COORD_BITS-1:0] yb,
   output pip_pkg::edge_res_type        result
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic                         vertical;
   logic                         on_vertical;
   logic                         swap;
   logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
   logic                         in_span;
   logic signed [DW-1:0]         dy_point, dx_edge, dy_edge, dx_point;
   logic signed [PW-1:0]         lhs, rhs;

   assign vertical    = (xa == xb);
   assign on_vertical = (point_x == xa) &&
                        (((ya <= point_y) && (point_y <= yb)) ||
                         ((yb <= point_y) && (point_y <= ya)));

   // Orient the edge left to right
   assign swap = (xa > xb);
   assign x0   = swap ? xb : xa;
   assign y0   = swap ? yb : ya;
   assign x1   = swap ? xa : xb;
   assign y1   = swap ? ya : yb;

   assign in_span = (point_x >= x0) && (point_x <= x1);

   assign dy_point = {point_y[COORD_BITS-1], point_y} - {y0[COORD_BITS-1], y0};
   assign dx_edge  = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
   assign dy_edge  = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
   assign dx_point = {point_x[COORD_BITS-1], point_x} - {x0[COORD_BITS-1], x0};

   // Exact slope compare by cross-multiplication; dx_edge is positive here
   assign lhs = dy_point * dx_edge;
   assign rhs = dy_edge * dx_point;

   always_comb begin
      result = '0;
      if (vertical) begin
         result.on_edge = on_vertical;
      end else if (in_span) begin
         result.on_edge  = (lhs == rhs);
         result.crossing = (lhs < rhs) && (x0 < point_x);
      end
   end

endmodule
